// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

   localparam int TICK_BITS = 8;
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
   localparam int CFG_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SPAN_W = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   localparam logic [2:0] FUNC_START     = 3'd1;
   localparam logic [2:0] FUNC_STOP      = 3'd2;
   localparam logic [2:0] FUNC_WRITE     = 3'd3;
   localparam logic [2:0] FUNC_READ_ACK  = 3'd4;
   localparam logic [2:0] FUNC_READ_NACK = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_TICKS        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_TICKS       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_STOP_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACK_TIMEOUT      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLL_TICKS       = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_STA1  = 4'd1,
      PH_STA2  = 4'd2,
      PH_STP1  = 4'd3,
      PH_STP2  = 4'd4,
      PH_WLO   = 4'd5,
      PH_WHI   = 4'd6,
      PH_AWAIT = 4'd7,
      PH_AHI   = 4'd8,
      PH_RLO   = 4'd9,
      PH_RHI   = 4'd10,
      PH_KLO   = 4'd11,
      PH_KHI   = 4'd12
   } phase_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_ok;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] low_ticks;
      logic [CFG_BITS-1:0] high_ticks;
      logic [CFG_BITS-1:0] start_stop_ticks;
      logic [CFG_BITS-1:0] ack_timeout;
      logic [CFG_BITS-1:0] poll_ticks;
   } cfg_type;

   function automatic logic [TICK_BITS-1:0] span(input logic [CFG_BITS-1:0] v);
      logic [SPAN_W-1:0] ve;
      logic [TICK_BITS-1:0] r;
      ve = SPAN_W'(v);
      if (v == '0) begin
         r = TICK_BITS'(1);
      end else if (ve > SPAN_W'(TICK_MAX)) begin
         r = TICK_MAX;
      end else begin
         r = TICK_BITS'(ve);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/i2cm_csr.sv =====
module i2cm_csr import i2cm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOW_TICKS:        cfg_in.low_ticks        = csr_wdata;
            CSR_HIGH_TICKS:       cfg_in.high_ticks       = csr_wdata;
            CSR_START_STOP_TICKS: cfg_in.start_stop_ticks = csr_wdata;
            CSR_ACK_TIMEOUT:      cfg_in.ack_timeout      = csr_wdata;
            CSR_POLL_TICKS:       cfg_in.poll_ticks       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_ticks        <= 8'd5;
         cfg_ff.high_ticks       <= 8'd5;
         cfg_ff.start_stop_ticks <= 8'd10;
         cfg_ff.ack_timeout      <= 8'd200;
         cfg_ff.poll_ticks       <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/i2cm_seq.sv =====
module i2cm_seq import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    acc,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   typedef struct packed {
      logic scl;
      logic sda;
   } drive_type;

   function automatic drive_type enter_drive(input phase_type p, input logic msb,
                                             input logic nack, input drive_type cur);
      drive_type d;
      d = cur;
      case (p)
         PH_STA1:  begin d.scl = 1'b1; d.sda = 1'b1; end
         PH_STA2:  d.sda = 1'b0;
         PH_STP1:  begin d.scl = 1'b0; d.sda = 1'b0; end
         PH_STP2:  d.scl = 1'b1;
         PH_WLO:   begin d.scl = 1'b0; d.sda = msb; end
         PH_WHI:   d.scl = 1'b1;
         PH_AWAIT: begin d.scl = 1'b0; d.sda = 1'b1; end
         PH_AHI:   d.scl = 1'b1;
         PH_RLO:   begin d.scl = 1'b0; d.sda = 1'b1; end
         PH_RHI:   d.scl = 1'b1;
         PH_KLO:   begin d.scl = 1'b0; d.sda = nack; end
         PH_KHI:   d.scl = 1'b1;
         default: ;
      endcase
      return d;
   endfunction

   phase_type            phase_ff, phase_in, cmd_phase;
   logic [3:0]           bit_count_ff, bit_count_in, cmd_bc, bc_inc;
   logic [7:0]           shift_ff, shift_in, cmd_shift;
   logic [TICK_BITS-1:0] tick_ff, tick_in, cmd_tick, tick_inc;
   logic [7:0]           poll_ff, poll_in;
   drive_type            drive_ff, drive_in, cmd_drive;
   logic                 ack_ff, ack_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 nack_ff, nack_in, cmd_nack;
   logic                 tos_ff, tos_in, cmd_tos;
   logic [CFG_BITS-1:0]  len;
   logic                 elapsed, byte_end, fin, done;

   // command decode while idle
   always_comb begin
      cmd_phase = phase_ff;
      cmd_bc    = bit_count_ff;
      cmd_shift = shift_ff;
      cmd_nack  = nack_ff;
      cmd_tos   = tos_ff;
      cmd_tick  = tick_ff;
      cmd_drive = drive_ff;
      if (phase_ff == PH_IDLE) begin
         unique case (req.func) inside
            FUNC_START: cmd_phase = PH_STA1;
            FUNC_STOP: begin
               cmd_tos   = 1'b0;
               cmd_phase = PH_STP1;
            end
            FUNC_WRITE: begin
               cmd_shift = req.tx_byte;
               cmd_bc    = 4'd0;
               cmd_phase = PH_WLO;
            end
            FUNC_READ_ACK, FUNC_READ_NACK: begin
               cmd_shift = 8'd0;
               cmd_bc    = 4'd0;
               cmd_nack  = (req.func == FUNC_READ_NACK);
               cmd_phase = PH_RLO;
            end
            default: ;
         endcase
         if (cmd_phase != PH_IDLE) begin
            cmd_tick  = '0;
            cmd_drive = enter_drive(cmd_phase, cmd_shift[7], cmd_nack, drive_ff);
         end
      end
   end

   always_comb begin
      case (cmd_phase) inside
         PH_STA1, PH_STA2, PH_STP1, PH_STP2: len = cfg.start_stop_ticks;
         PH_WHI, PH_AHI, PH_RHI, PH_KHI:     len = cfg.high_ticks;
         PH_AWAIT:                           len = cfg.poll_ticks;
         default:                            len = cfg.low_ticks;
      endcase
   end

   assign tick_inc = cmd_tick + TICK_BITS'(1);
   assign elapsed  = (tick_inc >= span(len));
   assign bc_inc   = cmd_bc + 4'd1;
   assign byte_end = (bc_inc >= BITS_PER_BYTE);

   // next phase
   always_comb begin
      phase_in = cmd_phase;
      fin      = 1'b0;
      unique case (cmd_phase)
         PH_IDLE: ;
         PH_STA1: if (elapsed) phase_in = PH_STA2;
         PH_STA2: if (elapsed) begin phase_in = PH_IDLE; fin = 1'b1; end
         PH_STP1: if (elapsed) phase_in = PH_STP2;
         PH_STP2: if (elapsed) begin phase_in = PH_IDLE; fin = 1'b1; end
         PH_WLO:  if (elapsed) phase_in = PH_WHI;
         PH_WHI:  if (elapsed) phase_in = byte_end ? PH_AWAIT : PH_WLO;
         PH_AWAIT: begin
            if (elapsed) begin
               if (!req.sda_in) begin
                  phase_in = PH_AHI;
               end else if (poll_ff >= cfg.ack_timeout) begin
                  phase_in = PH_STP1;
               end
            end
         end
         PH_AHI:  if (elapsed) begin phase_in = PH_IDLE; fin = 1'b1; end
         PH_RLO:  if (elapsed) phase_in = PH_RHI;
         PH_RHI:  if (elapsed) phase_in = byte_end ? PH_KLO : PH_RLO;
         PH_KLO:  if (elapsed) phase_in = PH_KHI;
         PH_KHI:  if (elapsed) begin phase_in = PH_IDLE; fin = 1'b1; end
         default: phase_in = PH_IDLE;
      endcase
   end

   // datapath and line drive
   always_comb begin
      bit_count_in = cmd_bc;
      shift_in     = cmd_shift;
      tick_in      = (cmd_phase == PH_IDLE) ? cmd_tick : tick_inc;
      poll_in      = poll_ff;
      drive_in     = cmd_drive;
      ack_in       = ack_ff;
      rx_in        = rx_ff;
      nack_in      = cmd_nack;
      tos_in       = cmd_tos;
      done         = 1'b0;
      unique case (cmd_phase)
         PH_STA2: if (elapsed) drive_in.scl = 1'b0;
         PH_STP2: begin
            if (elapsed) begin
               drive_in.sda = 1'b1;
               if (cmd_tos) begin
                  ack_in = 1'b0;
                  tos_in = 1'b0;
               end
            end
         end
         PH_WHI: begin
            if (elapsed) begin
               drive_in.scl = 1'b0;
               shift_in     = {cmd_shift[6:0], 1'b0};
               bit_count_in = bc_inc;
            end
         end
         PH_AWAIT: begin
            if (elapsed) begin
               tick_in = '0;
               if (req.sda_in) begin
                  if (poll_ff >= cfg.ack_timeout) begin
                     tos_in = 1'b1;
                  end else begin
                     poll_in = poll_ff + 8'd1;
                  end
               end
            end
         end
         PH_AHI: begin
            if (elapsed) begin
               drive_in.scl = 1'b0;
               ack_in       = 1'b1;
            end
         end
         PH_RHI: begin
            if (elapsed) begin
               shift_in     = {cmd_shift[6:0], req.sda_in};
               drive_in.scl = 1'b0;
               bit_count_in = bc_inc;
            end
         end
         PH_KHI: begin
            if (elapsed) begin
               drive_in.scl = 1'b0;
               rx_in        = cmd_shift;
            end
         end
         default: ;
      endcase
      if (fin) begin
         tick_in = '0;
         done    = 1'b1;
      end
      if ((phase_in != cmd_phase) && (phase_in != PH_IDLE)) begin
         tick_in  = '0;
         drive_in = enter_drive(phase_in, shift_in[7], cmd_nack, drive_in);
         if (phase_in == PH_AWAIT) begin
            poll_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         tick_ff      <= '0;
         poll_ff      <= 8'd0;
         drive_ff     <= '{scl: 1'b1, sda: 1'b1};
         ack_ff       <= 1'b0;
         rx_ff        <= 8'd0;
         nack_ff      <= 1'b0;
         tos_ff       <= 1'b0;
      end else if (acc) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         poll_ff      <= poll_in;
         drive_ff     <= drive_in;
         ack_ff       <= ack_in;
         rx_ff        <= rx_in;
         nack_ff      <= nack_in;
         tos_ff       <= tos_in;
      end
   end

   always_comb begin
      rsp.scl_out  = drive_in.scl;
      rsp.sda_out  = drive_in.sda;
      rsp.busy_res = (phase_in != PH_IDLE);
      rsp.done_res = done;
      rsp.rx_byte  = rx_in;
      rsp.ack_ok   = ack_in;
   end

endmodule

// ===== rtl/core/i2cm_out_buf.sv =====
module i2cm_out_buf import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   rsp_type main_ff, main_in, skid_ff, skid_in;
   logic    take;

   assign take = main_v_ff & ~rsp_stall;

   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!main_v_ff || take) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = push;
            skid_in   = push_data;
         end else begin
            main_in   = push_data;
            main_v_in = push;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_v_ff;
   assign rsp_valid = main_v_ff;
   assign rsp_data  = main_ff;

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master pin sequencer, one timing tick per req transaction. Each tick
// carries the sampled SDA level and, while idle, a command (start, stop,
// write byte, read byte with ACK or NACK); each tick returns one rsp
// transaction with the SCL and SDA drive, busy and done flags, the last
// received byte and the acknowledge status. The block takes one tick every
// clock while req_stall is low; results go to the rsp register, or to the
// skid stage while it is stalled. This two-entry buffer lets one tick in
// while a result waits, so req_stall rises only when two results wait. The
// user writes the csr phase lengths while idle; the block does not check.
module i2c_master_byte_engine import i2cm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   cfg_type cfg;
   rsp_type seq_rsp;
   logic    acc, full;

   assign req_stall = full;
   assign acc       = req_valid & ~full;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (seq_rsp)
   );

   i2cm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (acc),
      .push_data (seq_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/i2cm_checker.sv =====
module i2cm_checker import i2cm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_stall_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_stall)
      else $error("req_stall high right after reset");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted tick produced no rsp transaction");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done and busy in the same result");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
